/* sv/ugrq_pkg.sv */
// Shared types and constants of the uniform grid radius query unit.
// Holds the unit record, the query context and the opcode and register codes.
// No dependencies.
`default_nettype none

package ugrq_pkg;

  localparam int MAX_UNITS = 64;
  localparam int GRID_DIM  = 16;

  localparam int IDX_W   = $clog2(MAX_UNITS);
  localparam int CELL_W  = $clog2(GRID_DIM);
  localparam int POS_W   = 24;
  localparam int REL_W   = POS_W + 1;
  localparam int WIN_W   = REL_W + 1;
  localparam int SPAN_W  = 24;
  localparam int SQ_W    = 2 * REL_W - 1;
  localparam int D2_W    = SQ_W + 1;
  localparam int R2_W    = 2 * (POS_W - 1);
  localparam int TAG_W   = 32;
  localparam int MASK_W  = 64;
  localparam int CNT_W   = 7;
  localparam int SLOT_W  = 6;
  localparam int OP_W    = 3;
  localparam int SHIFT_W = 5;
  localparam int MDS_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
  localparam logic [OP_W-1:0] OP_FILL   = 3'd1;
  localparam logic [OP_W-1:0] OP_DISK   = 3'd2;
  localparam logic [OP_W-1:0] OP_SEP    = 3'd3;
  localparam logic [OP_W-1:0] OP_THREAT = 3'd4;
  localparam logic [OP_W-1:0] OP_COUNT  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST   = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    side;
    logic                    live;
    logic [TAG_W-1:0]        tag;
    logic [CELL_W-1:0]       cx;
    logic [CELL_W-1:0]       cy;
    logic                    binned;
  } unit_t;

  typedef struct packed {
    logic                    open_rng;
    logic                    need_side;
    logic                    need_tag;
    logic                    skip_self;
    logic                    side;
    logic [TAG_W-1:0]        tag;
    logic [IDX_W-1:0]        self_idx;
    logic signed [POS_W-1:0] ox;
    logic signed [POS_W-1:0] oy;
    logic signed [REL_W-1:0] icx;
    logic signed [REL_W-1:0] icy;
    logic [SPAN_W-1:0]       span;
    logic [R2_W-1:0]         r2;
    logic [MDS_W-1:0]        min_dist_sq;
  } query_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } step_t;

endpackage

`default_nettype wire

/* sv/ugrq_cell.sv */
// One cell of the rotating unit ring: stores a single unit record.
// Loads from its neighbor when the ring steps, or from the write port.
// Depends on ugrq_pkg.
`default_nettype none

module ugrq_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 shift_i,
  input  ugrq_pkg::unit_t     next_i,
  input  wire                 wr_i,
  input  ugrq_pkg::unit_t     wr_data_i,
  output ugrq_pkg::unit_t     rec_o
);
  import ugrq_pkg::*;

  logic signed [POS_W-1:0] x_q;
  logic signed [POS_W-1:0] y_q;
  logic                    side_q;
  logic                    live_q;
  logic [TAG_W-1:0]        tag_q;
  logic [CELL_W-1:0]       cx_q;
  logic [CELL_W-1:0]       cy_q;
  logic                    binned_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q   <= 1'b0;
      binned_q <= 1'b0;
    end else if (shift_i) begin
      live_q   <= next_i.live;
      binned_q <= next_i.binned;
    end else if (wr_i) begin
      live_q   <= wr_data_i.live;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      x_q    <= next_i.x;
      y_q    <= next_i.y;
      side_q <= next_i.side;
      tag_q  <= next_i.tag;
      cx_q   <= next_i.cx;
      cy_q   <= next_i.cy;
    end else if (wr_i) begin
      x_q    <= wr_data_i.x;
      y_q    <= wr_data_i.y;
      side_q <= wr_data_i.side;
      tag_q  <= wr_data_i.tag;
    end
  end

  always_comb begin
    rec_o.x      = x_q;
    rec_o.y      = y_q;
    rec_o.side   = side_q;
    rec_o.live   = live_q;
    rec_o.tag    = tag_q;
    rec_o.cx     = cx_q;
    rec_o.cy     = cy_q;
    rec_o.binned = binned_q;
  end

endmodule

`default_nettype wire

/* sv/ugrq_eval.sv */
// Three-stage test of the unit record at the head of the ring against a query.
// Stages: window and deltas, squares, distance compare and hit accumulation.
// Depends on ugrq_pkg.
`default_nettype none

module ugrq_eval (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  input  ugrq_pkg::step_t             step_i,
  input  ugrq_pkg::unit_t             rec_i,
  input  ugrq_pkg::query_t            ctx_i,
  output logic [ugrq_pkg::MASK_W-1:0] mask_o,
  output logic [ugrq_pkg::CNT_W-1:0]  count_o,
  output logic                        done_o
);
  import ugrq_pkg::*;

  logic signed [WIN_W-1:0] wx;
  logic signed [WIN_W-1:0] wy;
  logic [WIN_W-1:0]        ax;
  logic [WIN_W-1:0]        ay;
  logic                    in_win;
  logic                    pre_ok;
  logic signed [REL_W-1:0] dx;
  logic signed [REL_W-1:0] dy;

  logic                    a_valid_q;
  logic                    a_last_q;
  logic                    a_ok_q;
  logic [IDX_W-1:0]        a_idx_q;
  logic signed [REL_W-1:0] a_dx_q;
  logic signed [REL_W-1:0] a_dy_q;

  logic signed [2*REL_W-1:0] prod_x;
  logic signed [2*REL_W-1:0] prod_y;

  logic             b_valid_q;
  logic             b_last_q;
  logic             b_ok_q;
  logic [IDX_W-1:0] b_idx_q;
  logic [SQ_W-1:0]  b_sqx_q;
  logic [SQ_W-1:0]  b_sqy_q;

  logic [D2_W-1:0]   d2;
  logic              hit;
  logic [MASK_W-1:0] mask_q;
  logic [CNT_W-1:0]  count_q;
  logic              done_q;

  always_comb begin
    wx = $signed({{(WIN_W-CELL_W){1'b0}}, rec_i.cx}) - $signed({ctx_i.icx[REL_W-1], ctx_i.icx});
    wy = $signed({{(WIN_W-CELL_W){1'b0}}, rec_i.cy}) - $signed({ctx_i.icy[REL_W-1], ctx_i.icy});
    ax = wx[WIN_W-1] ? WIN_W'(-wx) : WIN_W'(wx);
    ay = wy[WIN_W-1] ? WIN_W'(-wy) : WIN_W'(wy);
    in_win = (ax <= {{(WIN_W-SPAN_W){1'b0}}, ctx_i.span}) &&
             (ay <= {{(WIN_W-SPAN_W){1'b0}}, ctx_i.span});
    pre_ok = rec_i.binned && rec_i.live && in_win &&
             (!ctx_i.need_side || (rec_i.side == ctx_i.side)) &&
             (!ctx_i.need_tag || (rec_i.tag != ctx_i.tag)) &&
             (!ctx_i.skip_self || (step_i.idx != ctx_i.self_idx));
    dx = $signed({rec_i.x[POS_W-1], rec_i.x}) - $signed({ctx_i.ox[POS_W-1], ctx_i.ox});
    dy = $signed({rec_i.y[POS_W-1], rec_i.y}) - $signed({ctx_i.oy[POS_W-1], ctx_i.oy});
  end

  assign prod_x = a_dx_q * a_dx_q;
  assign prod_y = a_dy_q * a_dy_q;

  always_comb begin
    d2 = {1'b0, b_sqx_q} + {1'b0, b_sqy_q};
    if (ctx_i.open_rng) begin
      hit = b_ok_q && (d2 > {{(D2_W-MDS_W){1'b0}}, ctx_i.min_dist_sq}) &&
            (d2 < {{(D2_W-R2_W){1'b0}}, ctx_i.r2});
    end else begin
      hit = b_ok_q && (d2 <= {{(D2_W-R2_W){1'b0}}, ctx_i.r2});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_last_q  <= 1'b0;
      b_valid_q <= 1'b0;
      b_last_q  <= 1'b0;
      mask_q    <= '0;
      count_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      a_valid_q <= step_i.valid;
      a_last_q  <= step_i.valid && step_i.last;
      b_valid_q <= a_valid_q;
      b_last_q  <= a_valid_q && a_last_q;
      done_q    <= b_valid_q && b_last_q;
      if (start_i) begin
        mask_q  <= '0;
        count_q <= '0;
      end else if (b_valid_q && hit) begin
        mask_q  <= mask_q | (MASK_W'(1) << b_idx_q);
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_ok_q  <= pre_ok;
    a_idx_q <= step_i.idx;
    a_dx_q  <= dx;
    a_dy_q  <= dy;
    b_ok_q  <= a_ok_q;
    b_idx_q <= a_idx_q;
    b_sqx_q <= prod_x[SQ_W-1:0];
    b_sqy_q <= prod_y[SQ_W-1:0];
  end

  assign mask_o  = mask_q;
  assign count_o = count_q;
  assign done_o  = done_q;

`ifndef SYNTHESIS
  a_count_matches_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(mask_q) == int'(count_q))
    else $error("hit count differs from the number of mask bits");

  a_last_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && a_last_q) |=> (b_valid_q && b_last_q))
    else $error("final slot lost between window and square stages");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (mask_q == '0 && count_q == '0))
    else $error("accumulators not cleared at query start");
`endif

endmodule

`default_nettype wire

/* sv/uniform_grid_radius_query_unit.sv */
// Top level of the uniform grid radius query unit: control, binning and ring.
// Instantiates ugrq_cell (one per unit slot) and ugrq_eval; uses ugrq_pkg.
//
//   channel  direction  handshake                 payload
//   in       to block   in_valid_i / in_stall_o   opcode, slot, pos, side, live, tag, mask, radius
//   out      from block out_valid_o / out_stall_i hit_mask_o, hit_count_o
//   cfg      to block   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A bin fill and every query with a positive radius are paced by the ring of unit cells
// turning one slot per cycle; a query moves each slot past the single distance tester,
// and a neighbor count turns the ring once more to fetch its own position.
// One item is in work at a time; the next beat is taken while a result still waits.
// Reset clears the alive and binned flags of every slot and resets the control and configuration registers.
`default_nettype none

module uniform_grid_radius_query_unit (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [ugrq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [ugrq_pkg::POS_W-1:0]          cfg_data_i,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  [ugrq_pkg::OP_W-1:0]           opcode_i,
  input  wire  [ugrq_pkg::SLOT_W-1:0]         slot_i,
  input  wire  signed [ugrq_pkg::POS_W-1:0]   pos_x_i,
  input  wire  signed [ugrq_pkg::POS_W-1:0]   pos_y_i,
  input  wire                                 side_i,
  input  wire                                 live_i,
  input  wire  [ugrq_pkg::TAG_W-1:0]          tag_i,
  input  wire  [ugrq_pkg::MASK_W-1:0]         member_mask_i,
  input  wire  signed [ugrq_pkg::POS_W-1:0]   radius_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [ugrq_pkg::MASK_W-1:0]         hit_mask_o,
  output logic [ugrq_pkg::CNT_W-1:0]          hit_count_o
);
  import ugrq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_FILL, ST_SELF, ST_SCAN, ST_DRAIN, ST_FINISH
  } state_e;

  function automatic logic [CELL_W-1:0] clamp_cell(input logic signed [REL_W-1:0] v);
    logic [CELL_W-1:0] c;
    if (v[REL_W-1]) begin
      c = '0;
    end else if (v > $signed(REL_W'(GRID_DIM - 1))) begin
      c = CELL_W'(GRID_DIM - 1);
    end else begin
      c = v[CELL_W-1:0];
    end
    return c;
  endfunction

  state_e state_q;
  logic [IDX_W-1:0]  idx_q;
  logic              use_eval_q;
  logic              out_valid_q;
  logic [MASK_W-1:0] hit_mask_q;
  logic [CNT_W-1:0]  hit_count_q;

  logic signed [POS_W-1:0] world_min_q;
  logic [SHIFT_W-1:0]      cell_shift_q;
  logic [MDS_W-1:0]        min_dist_sq_q;

  logic [OP_W-1:0]         op_q;
  logic [SLOT_W-1:0]       slot_q;
  logic signed [POS_W-1:0] px_q;
  logic signed [POS_W-1:0] py_q;
  logic                    side_q;
  logic [TAG_W-1:0]        tag_q;
  logic [POS_W-1:0]        radius_q;
  logic [MASK_W-1:0]       mem_q;
  logic signed [POS_W-1:0] ox_q;
  logic signed [POS_W-1:0] oy_q;
  logic signed [REL_W-1:0] icx_q;
  logic signed [REL_W-1:0] icy_q;
  logic [SPAN_W-1:0]       span_q;
  logic [R2_W-1:0]         r2_q;

  logic in_acc;
  logic out_take;
  logic slot_ok;
  logic rad_pos;
  logic is_query;
  logic wr_any;
  logic ring_step;
  logic last_step;

  logic signed [REL_W-1:0] rel_x;
  logic signed [REL_W-1:0] rel_y;
  logic [POS_W+8:0]        span_sum;
  logic [SPAN_W-1:0]       span_d;
  logic [R2_W-1:0]         r2_d;
  logic signed [REL_W-1:0] fill_rx;
  logic signed [REL_W-1:0] fill_ry;

  unit_t  rec [MAX_UNITS];
  unit_t  head;
  unit_t  wrap;
  unit_t  wr_rec;
  query_t ctx;
  step_t  step;

  logic [MASK_W-1:0] eval_mask;
  logic [CNT_W-1:0]  eval_count;
  logic              eval_done;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign slot_ok    = ({1'b0, slot_i} < (SLOT_W+1)'(MAX_UNITS));
  assign rad_pos    = !radius_i[POS_W-1] && (|radius_i);
  assign is_query   = rad_pos && ((opcode_i == OP_DISK) || (opcode_i == OP_SEP) ||
                      (opcode_i == OP_THREAT) || ((opcode_i == OP_COUNT) && slot_ok));
  assign wr_any     = in_acc && (opcode_i == OP_WRITE) && slot_ok;
  assign ring_step  = (state_q == ST_FILL) || (state_q == ST_SELF) || (state_q == ST_SCAN);
  assign last_step  = (idx_q == IDX_W'(MAX_UNITS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      world_min_q   <= '0;
      cell_shift_q  <= SHIFT_W'(8);
      min_dist_sq_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WORLD_MIN:  world_min_q   <= cfg_data_i;
        CFG_CELL_SHIFT: cell_shift_q  <= cfg_data_i[SHIFT_W-1:0];
        CFG_MIN_DIST:   min_dist_sq_q <= cfg_data_i[MDS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rel_x    = $signed({px_q[POS_W-1], px_q}) - $signed({world_min_q[POS_W-1], world_min_q});
    rel_y    = $signed({py_q[POS_W-1], py_q}) - $signed({world_min_q[POS_W-1], world_min_q});
    span_sum = {9'b0, radius_q} + ((POS_W+9)'(1) << cell_shift_q) - (POS_W+9)'(1);
    span_d   = SPAN_W'(span_sum >> cell_shift_q) + SPAN_W'(1);
    r2_d     = radius_q[POS_W-2:0] * radius_q[POS_W-2:0];
  end

  always_comb begin
    head    = rec[0];
    fill_rx = $signed({head.x[POS_W-1], head.x}) -
              $signed({world_min_q[POS_W-1], world_min_q});
    fill_ry = $signed({head.y[POS_W-1], head.y}) -
              $signed({world_min_q[POS_W-1], world_min_q});
    wrap    = head;
    if (state_q == ST_FILL) begin
      wrap.binned = mem_q[0] && head.live;
      wrap.cx     = clamp_cell(fill_rx >>> cell_shift_q);
      wrap.cy     = clamp_cell(fill_ry >>> cell_shift_q);
    end
  end

  always_comb begin
    wr_rec.x      = pos_x_i;
    wr_rec.y      = pos_y_i;
    wr_rec.side   = side_i;
    wr_rec.live   = live_i;
    wr_rec.tag    = tag_i;
    wr_rec.cx     = '0;
    wr_rec.cy     = '0;
    wr_rec.binned = 1'b0;
  end

  for (genvar k = 0; k < MAX_UNITS; k++) begin : g_ring
    unit_t nxt;
    if (k == MAX_UNITS - 1) begin : g_tail
      assign nxt = wrap;
    end else begin : g_body
      assign nxt = rec[k+1];
    end
    ugrq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (ring_step),
      .next_i    (nxt),
      .wr_i      (wr_any && (slot_i == SLOT_W'(k))),
      .wr_data_i (wr_rec),
      .rec_o     (rec[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= opcode_i;
      slot_q   <= slot_i;
      px_q     <= pos_x_i;
      py_q     <= pos_y_i;
      side_q   <= side_i;
      tag_q    <= tag_i;
      radius_q <= radius_i;
      mem_q    <= member_mask_i;
    end else if (state_q == ST_FILL) begin
      mem_q    <= mem_q >> 1;
    end
    if (state_q == ST_PREP) begin
      icx_q  <= rel_x >>> cell_shift_q;
      icy_q  <= rel_y >>> cell_shift_q;
      span_q <= span_d;
      r2_q   <= r2_d;
      ox_q   <= px_q;
      oy_q   <= py_q;
    end else if ((state_q == ST_SELF) && (idx_q == slot_q[IDX_W-1:0])) begin
      ox_q   <= head.x;
      oy_q   <= head.y;
    end
  end

  always_comb begin
    ctx.open_rng    = (op_q == OP_SEP) || (op_q == OP_THREAT);
    ctx.need_side   = (op_q == OP_DISK) || (op_q == OP_SEP);
    ctx.need_tag    = (op_q == OP_SEP);
    ctx.skip_self   = (op_q == OP_COUNT);
    ctx.side        = side_q;
    ctx.tag         = tag_q;
    ctx.self_idx    = slot_q[IDX_W-1:0];
    ctx.ox          = ox_q;
    ctx.oy          = oy_q;
    ctx.icx         = icx_q;
    ctx.icy         = icy_q;
    ctx.span        = span_q;
    ctx.r2          = r2_q;
    ctx.min_dist_sq = min_dist_sq_q;
    step.valid      = (state_q == ST_SCAN);
    step.last       = last_step;
    step.idx        = idx_q;
  end

  ugrq_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_PREP),
    .step_i  (step),
    .rec_i   (head),
    .ctx_i   (ctx),
    .mask_o  (eval_mask),
    .count_o (eval_count),
    .done_o  (eval_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      use_eval_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hit_mask_q  <= '0;
      hit_count_q <= '0;
    end else begin
      if (out_take) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            use_eval_q <= is_query;
            idx_q      <= '0;
            if (opcode_i == OP_FILL) begin
              state_q <= ST_FILL;
            end else if (is_query) begin
              state_q <= ST_PREP;
            end else begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_PREP: begin
          idx_q   <= '0;
          state_q <= (op_q == OP_COUNT) ? ST_SELF : ST_SCAN;
        end
        ST_FILL, ST_SELF, ST_SCAN: begin
          if (last_step) begin
            idx_q <= '0;
            if (state_q == ST_FILL) begin
              state_q <= ST_FINISH;
            end else if (state_q == ST_SELF) begin
              state_q <= ST_SCAN;
            end else begin
              state_q <= ST_DRAIN;
            end
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (eval_done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || out_take) begin
            out_valid_q <= 1'b1;
            hit_mask_q  <= use_eval_q ? eval_mask : '0;
            hit_count_q <= use_eval_q ? eval_count : '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_mask_o  = hit_mask_q;
  assign hit_count_o = hit_count_q;

`ifndef SYNTHESIS
  a_scan_ends_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && last_step) |=> (state_q == ST_DRAIN))
    else $error("scan pass did not end after the last slot");

  a_write_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == OP_WRITE) |=> (state_q == ST_FINISH))
    else $error("unit write did not go straight to the result");

  a_idx_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FILL && state_q != ST_SELF && state_q != ST_SCAN) |-> (idx_q == '0))
    else $error("slot counter left off home position");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_count_o <= CNT_W'(MAX_UNITS)))
    else $error("hit count above the number of slots");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for uniform_grid_radius_query_unit.
// It drives a directed table, then random beats under several register settings, and
// checks each result with its grid search model or the table's hits. Uses ugrq_pkg.
`timescale 1ns / 1ps

module tb_top;
  import ugrq_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int RAND_PER_SETTING = 125;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic              side;
    logic              live;
    logic [TAG_W-1:0]  tag;
    logic [MASK_W-1:0] members;
    logic [POS_W-1:0]  radius;
  } cmd_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [CNT_W-1:0]  count;
  } hits_t;

  typedef struct packed {
    cmd_t  c;
    logic  typed;
    hits_t want;
  } row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [POS_W-1:0]  cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [OP_W-1:0]   opcode_i;
  logic [SLOT_W-1:0] slot_i;
  logic [POS_W-1:0]  pos_x_i;
  logic [POS_W-1:0]  pos_y_i;
  logic              side_i;
  logic              live_i;
  logic [TAG_W-1:0]  tag_i;
  logic [MASK_W-1:0] member_mask_i;
  logic [POS_W-1:0]  radius_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [MASK_W-1:0] hit_mask_o;
  logic [CNT_W-1:0]  hit_count_o;

  uniform_grid_radius_query_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .slot_i       (slot_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .side_i       (side_i),
    .live_i       (live_i),
    .tag_i        (tag_i),
    .member_mask_i(member_mask_i),
    .radius_i     (radius_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_mask_o   (hit_mask_o),
    .hit_count_o  (hit_count_o)
  );

  // Model state of the unit table and the registers.
  longint      ux_tab [MAX_UNITS];
  longint      uy_tab [MAX_UNITS];
  bit          side_tab [MAX_UNITS];
  bit          live_tab [MAX_UNITS];
  bit          binned_tab [MAX_UNITS];
  bit          ever_set [MAX_UNITS];
  logic [31:0] tag_tab [MAX_UNITS];
  int          cellx_tab [MAX_UNITS];
  int          celly_tab [MAX_UNITS];
  longint      world_lo = 0;
  int          cell_log2 = 8;
  longint      coincide_sq = 0;

  hits_t       hits_due [$];
  logic [31:0] tag_pool [4];
  row_t        plan [];
  bit          hush = 1'b0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          beats_sent = 0;
  int          hit_queries = 0;
  int          settings = 1;
  int          stall_left = 0;
  int          calm_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < 40) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [POS_W-1:0] clip24(input longint v);
    if (v > 8388607) return 24'h7FFFFF;
    if (v < -8388608) return 24'h800000;
    return v[POS_W-1:0];
  endfunction

  function automatic int grid_coord(input longint p);
    longint g;
    g = (p - world_lo) >>> cell_log2;
    if (g < 0) return 0;
    if (g > GRID_DIM - 1) return GRID_DIM - 1;
    return int'(g);
  endfunction

  function automatic logic [POS_W-1:0] near_pos();
    longint cs;
    cs = longint'(1) << cell_log2;
    return clip24(world_lo - cs + longint'($urandom_range(0, 18 * cs - 1)));
  endfunction

  // Applies one beat to the model table and returns the hits it produces.
  function automatic hits_t grid_search(input cmd_t c);
    hits_t  r;
    longint px, py, rad, cs, icx, icy, span, r2, ox, oy, dx, dy, d2;
    bit     hit;
    r = '0;
    px = $signed(c.px);
    py = $signed(c.py);
    rad = $signed(c.radius);
    if (c.op == OP_WRITE) begin
      ux_tab[c.slot] = px;
      uy_tab[c.slot] = py;
      side_tab[c.slot] = c.side;
      live_tab[c.slot] = c.live;
      tag_tab[c.slot] = c.tag;
      ever_set[c.slot] = 1'b1;
    end else if (c.op == OP_FILL) begin
      for (int i = 0; i < MAX_UNITS; i++) begin
        binned_tab[i] = c.members[i] && live_tab[i];
        if (binned_tab[i]) begin
          cellx_tab[i] = grid_coord(ux_tab[i]);
          celly_tab[i] = grid_coord(uy_tab[i]);
        end
      end
    end else if (c.op <= OP_COUNT && rad > 0) begin
      cs = longint'(1) << cell_log2;
      icx = (px - world_lo) >>> cell_log2;
      icy = (py - world_lo) >>> cell_log2;
      span = ((rad + cs - 1) >> cell_log2) + 1;
      r2 = rad * rad;
      ox = (c.op == OP_COUNT) ? ux_tab[c.slot] : px;
      oy = (c.op == OP_COUNT) ? uy_tab[c.slot] : py;
      for (int i = 0; i < MAX_UNITS; i++) begin
        if (!binned_tab[i] || !live_tab[i]) continue;
        if (cellx_tab[i] - icx > span || icx - cellx_tab[i] > span) continue;
        if (celly_tab[i] - icy > span || icy - celly_tab[i] > span) continue;
        dx = ux_tab[i] - ox;
        dy = uy_tab[i] - oy;
        d2 = dx * dx + dy * dy;
        case (c.op)
          OP_DISK:   hit = side_tab[i] == c.side && d2 <= r2;
          OP_SEP:    hit = side_tab[i] == c.side && tag_tab[i] != c.tag &&
                           d2 > coincide_sq && d2 < r2;
          OP_THREAT: hit = d2 > coincide_sq && d2 < r2;
          default:   hit = i != int'(c.slot) && d2 <= r2;
        endcase
        if (hit) begin
          r.mask[i] = 1'b1;
          r.count = r.count + 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic row_t mk(input logic [OP_W-1:0] op, input int slot, input int x,
                              input int y, input bit side, input bit live,
                              input logic [31:0] tag, input logic [63:0] members,
                              input int radius, input bit typed, input logic [63:0] mask,
                              input int n);
    row_t r;
    r.c = '{op, slot[5:0], x[23:0], y[23:0], side, live, tag, members, radius[23:0]};
    r.typed = typed;
    r.want = '{mask, n[6:0]};
    return r;
  endfunction

  // Presents one beat, starting and ending at a falling edge.
  task automatic drive_beat(input cmd_t c, input bit typed, input hits_t want);
    hits_t calc;
    int    gap;
    gap = (!hush && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    opcode_i <= c.op;
    slot_i <= c.slot;
    pos_x_i <= c.px;
    pos_y_i <= c.py;
    side_i <= c.side;
    live_i <= c.live;
    tag_i <= c.tag;
    member_mask_i <= c.members;
    radius_i <= c.radius;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    calc = grid_search(c);
    if (c.op >= OP_DISK && c.op <= OP_COUNT && calc.count != 0) hit_queries++;
    hits_due.push_back(typed ? want : calc);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic program_regs(input longint wm, input int sh, input int mds);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_WORLD_MIN;
    cfg_data_i <= wm[23:0];
    @(negedge clk_i);
    cfg_idx_i <= CFG_CELL_SHIFT;
    cfg_data_i <= sh;
    @(negedge clk_i);
    cfg_idx_i <= CFG_MIN_DIST;
    cfg_data_i <= mds;
    @(negedge clk_i);
    cfg_idx_i <= CFG_SPARE;
    cfg_data_i <= $urandom;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    world_lo = wm;
    cell_log2 = sh;
    coincide_sq = mds;
    settings++;
  endtask

  task automatic random_phase(input int n);
    cmd_t   c;
    int     j;
    longint k, cs;
    for (int m = 0; m < n; m++) begin
      c.slot = $urandom_range(0, MAX_UNITS - 1);
      c.px = $urandom;
      c.py = $urandom;
      c.side = $urandom;
      c.live = $urandom;
      c.tag = $urandom;
      c.members = {$urandom, $urandom};
      c.radius = $urandom;
      cs = longint'(1) << cell_log2;
      j = $urandom_range(0, 99);
      if (j < 35) begin
        c.op = OP_WRITE;
        c.live = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 9) != 0) begin
          c.px = near_pos();
          c.py = near_pos();
        end
        if ($urandom_range(0, 1)) c.tag = tag_pool[$urandom_range(0, 3)];
      end else if (j < 43) begin
        c.op = OP_FILL;
        case ($urandom_range(0, 5))
          0: c.members = '1;
          1: ;
          default: c.members = c.members | {$urandom, $urandom};
        endcase
      end else if (j < 97) begin
        c.op = $urandom_range(OP_DISK, OP_COUNT);
        j = $urandom_range(0, MAX_UNITS - 1);
        while (!ever_set[j]) j = $urandom_range(0, MAX_UNITS - 1);
        if (c.op == OP_COUNT) c.slot = j;
        if ($urandom_range(0, 9) < 6) begin
          k = longint'(1) << $urandom_range(0, cell_log2 + 2);
          if ($urandom_range(0, 4) == 0) k = 0;
          c.px = clip24(ux_tab[j] + longint'($urandom_range(0, 2 * k)) - k);
          c.py = clip24(uy_tab[j] + longint'($urandom_range(0, 2 * k)) - k);
        end else begin
          c.px = near_pos();
          c.py = near_pos();
        end
        if ($urandom_range(0, 1)) c.tag = tag_tab[j];
        case ($urandom_range(0, 9))
          0: c.radius = '0;
          1: c.radius = clip24(-longint'($urandom_range(1, 8388608)));
          2: c.radius = 24'h7FFFFF;
          3, 4: c.radius = $urandom_range(1, 400);
          default: c.radius = clip24(longint'($urandom_range(1, cs << $urandom_range(0, 3))));
        endcase
      end else begin
        c.op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
      end
      drive_beat(c, 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) begin
    if (hush || !rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (calm_left > 0) begin
        calm_left--;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:14]:  stall_left = $urandom_range(1, 5);
          [15:17]: calm_left = $urandom_range(20, 80);
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    hits_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (hits_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result mask %h count %0d",
                                hit_mask_o, hit_count_o));
      end else begin
        want = hits_due.pop_front();
        if (hit_mask_o !== want.mask)
          flag_mismatch($sformatf("result %0d hit_mask %h, model %h",
                                  results_seen, hit_mask_o, want.mask));
        if (hit_count_o !== want.count)
          flag_mismatch($sformatf("result %0d hit_count %0d, model %0d",
                                  results_seen, hit_count_o, want.count));
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_WORLD_MIN;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    opcode_i <= OP_WRITE;
    slot_i <= '0;
    pos_x_i <= '0;
    pos_y_i <= '0;
    side_i <= 1'b0;
    live_i <= 1'b0;
    tag_i <= '0;
    member_mask_i <= '0;
    radius_i <= '0;
    out_stall_i <= 1'b0;
    foreach (tag_pool[i]) tag_pool[i] = $urandom;
    plan = '{
      mk(OP_DISK,   0, 0, 0, 0, 0, 0, 0, 256, 1, 0, 0),
      mk(OP_SPARE6, 5, 100, -7, 1, 1, 32'hA5A5_0F0F, '1, 999, 1, 0, 0),
      mk(OP_SPARE7, 63, -1, 42, 1, 0, 32'h1234_5678, '1, 1, 1, 0, 0),
      mk(OP_WRITE,  0, 0, 0, 0, 1, 1, 0, 0, 1, 0, 0),
      mk(OP_WRITE,  63, 8388607, 8388607, 1, 1, 32'hFFFF_FFFF, 0, 0, 1, 0, 0),
      mk(OP_WRITE,  1, -8388608, -8388608, 0, 1, 0, 0, 0, 1, 0, 0),
      mk(OP_WRITE,  2, 256, 0, 0, 1, 1, 0, 0, 1, 0, 0),
      mk(OP_WRITE,  3, 0, 256, 1, 0, 7, 0, 0, 1, 0, 0),
      mk(OP_WRITE,  4, 768, 1024, 0, 1, 5, 0, 0, 1, 0, 0),
      mk(OP_FILL,   0, 0, 0, 0, 0, 0, '1, 0, 1, 0, 0),
      mk(OP_DISK,   0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0),
      mk(OP_DISK,   0, 0, 0, 0, 0, 0, 0, -8388608, 1, 0, 0),
      mk(OP_COUNT,  0, 0, 0, 0, 0, 0, 0, -1, 1, 0, 0),
      mk(OP_DISK,   0, 0, 0, 0, 0, 0, 0, 256, 0, 0, 0),
      mk(OP_SEP,    0, 0, 0, 0, 0, 5, 0, 300, 0, 0, 0),
      mk(OP_SEP,    0, 0, 0, 0, 0, 1, 0, 300, 0, 0, 0),
      mk(OP_THREAT, 0, 0, 0, 0, 0, 0, 0, 8388607, 0, 0, 0),
      mk(OP_COUNT,  0, 0, 0, 0, 0, 0, 0, 1280, 0, 0, 0),
      mk(OP_COUNT,  63, 8388607, 8388607, 1, 0, 0, 0, 8388607, 0, 0, 0),
      mk(OP_WRITE,  4, 0, 0, 0, 1, 5, 0, 0, 1, 0, 0),
      mk(OP_DISK,   0, 0, 0, 0, 0, 0, 0, 16, 0, 0, 0),
      mk(OP_WRITE,  2, 256, 0, 0, 0, 1, 0, 0, 1, 0, 0),
      mk(OP_FILL,   0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0),
      mk(OP_THREAT, 0, 0, 0, 0, 0, 0, 0, 8388607, 1, 0, 0),
      mk(OP_FILL,   0, 0, 0, 0, 0, 0, 64'h8000_0000_0000_0003, 0, 1, 0, 0),
      mk(OP_THREAT, 0, -8388608, -8388608, 0, 0, 0, 0, 8388607, 0, 0, 0)
    };
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (plan[i]) drive_beat(plan[i].c, plan[i].typed, plan[i].want);
    for (int p = 0; p < 6; p++) begin
      in_valid_i <= 1'b0;
      while (hits_due.size() != 0) @(negedge clk_i);
      repeat (2) @(negedge clk_i);
      case (p)
        0: program_regs(-4096, 8, 0);
        1: program_regs(-8388608, 22, 65535);
        2: program_regs(8388607, 0, 0);
        3: program_regs(longint'($urandom_range(0, 2097152)) - 1048576,
                        $urandom_range(0, 22), $urandom_range(0, 65535));
        4: program_regs(-2048, 4, 100);
        default: program_regs(longint'($urandom_range(0, 2097152)) - 1048576,
                              $urandom_range(3, 12), $urandom_range(0, 65535));
      endcase
      hush = (p == 5);
      random_phase(RAND_PER_SETTING);
    end
    in_valid_i <= 1'b0;
    while (hits_due.size() != 0) @(negedge clk_i);
    repeat (2 * MAX_UNITS + 8) @(posedge clk_i);
    $display("Sent %0d beats under %0d register settings; %0d queries found hits.",
             beats_sent, settings, hit_queries);
    $display("Compared %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
